[rtl/projective_point_transform_2d_defines.svh]
// Assertion macros shared by the projective point transform RTL.
`ifndef PROJECTIVE_POINT_TRANSFORM_2D_DEFINES_SVH
`define PROJECTIVE_POINT_TRANSFORM_2D_DEFINES_SVH
`ifndef ASSERT_OFF
// Check a condition on every clock edge outside reset.
`define PPT_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
// Check that a condition implies another one in the same cycle.
`define PPT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define PPT_ASSERT(lbl, expr, msg)
`define PPT_ASSERT_IMPL(lbl, ante, cons, msg)
`endif
`endif

[rtl/ppt_pkg.sv]
// Shared types and constants for the projective point transform.
package ppt_pkg;

  localparam int COORD_W = 32;
  localparam int QUO_W   = COORD_W + 1;
  localparam int DIV_LAT = QUO_W + 1;

  typedef enum logic [2:0] {
    REG_COEF_M00_M01 = 3'd0,
    REG_COEF_M02_M10 = 3'd1,
    REG_COEF_M11_M12 = 3'd2,
    REG_COEF_M20_M21 = 3'd3,
    REG_COEF_M22     = 3'd4,
    REG_NEAR_ZERO    = 3'd5,
    REG_SYSTEM_OPEN  = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_CLOSED    = 2'd1,
    STAT_NEAR_ZERO = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
  } point_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] result_x;
    logic signed [COORD_W-1:0] result_y;
    status_t                   status;
  } result_t;

  typedef struct packed {
    status_t status;
    logic    neg_x;
    logic    neg_y;
  } ctl_t;

endpackage

[rtl/projective_point_transform_2d.sv]
// Top level of the projective 2D point transform by a 3x3 homogeneous matrix.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+---------------------------------
//  point    | point_valid / point_ready  | point_x, point_y (Q format)
//  result   | result_valid / result_ready| result_x, result_y, status
//  config   | psel/penable/pwrite/pready | paddr, pwdata, prdata (64 bit)
//
// One point enters per cycle while the output is not stalled; each result
// passes through three stages of multiply, sum and magnitude, a 34-stage
// divider (33 quotient bits plus the overflow check) and the output register.
// Reset empties the pipeline and loads the identity matrix.
// A stalled result freezes every stage together; point_ready drops with it.
module projective_point_transform_2d #(
  parameter int FRAC_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [5:0]       paddr,
  input  logic [63:0]      pwdata,
  output logic [63:0]      prdata,
  output logic             pready,
  input  logic             point_valid,
  output logic             point_ready,
  input  ppt_pkg::point_t  point,
  output logic             result_valid,
  input  logic             result_ready,
  output ppt_pkg::result_t result
);

`include "projective_point_transform_2d_defines.svh"

  localparam int CW   = ppt_pkg::COORD_W;
  localparam int PW   = 32 + CW;
  localparam int SW   = PW + 2;
  localparam int NW   = SW + FRAC_BITS;
  localparam int QB   = ppt_pkg::QUO_W;
  localparam int LAT  = ppt_pkg::DIV_LAT;
  localparam int LIMW = 31 + FRAC_BITS;
  localparam int CMPW = SW + LIMW;

  // Configuration registers
  logic [63:0]        coef_m00_m01, coef_m02_m10, coef_m11_m12, coef_m20_m21;
  logic signed [31:0] coef_m22;
  logic [30:0]        near_zero_limit;
  logic               system_open;
  ppt_pkg::reg_idx_t  reg_idx;
  logic               cfg_write;

  assign pready    = 1'b1;
  assign reg_idx   = ppt_pkg::reg_idx_t'(paddr[5:3]);
  assign cfg_write = psel && penable && pwrite;

  // Write a register on the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_m00_m01    <= 64'(1) << (32 + FRAC_BITS);
      coef_m02_m10    <= '0;
      coef_m11_m12    <= 64'(1) << (32 + FRAC_BITS);
      coef_m20_m21    <= '0;
      coef_m22        <= 32'(1) << FRAC_BITS;
      near_zero_limit <= 31'd1;
      system_open     <= 1'b1;
    end else if (cfg_write) begin
      case (reg_idx)
        ppt_pkg::REG_COEF_M00_M01: coef_m00_m01    <= pwdata;
        ppt_pkg::REG_COEF_M02_M10: coef_m02_m10    <= pwdata;
        ppt_pkg::REG_COEF_M11_M12: coef_m11_m12    <= pwdata;
        ppt_pkg::REG_COEF_M20_M21: coef_m20_m21    <= pwdata;
        ppt_pkg::REG_COEF_M22:     coef_m22        <= pwdata[31:0];
        ppt_pkg::REG_NEAR_ZERO:    near_zero_limit <= pwdata[30:0];
        ppt_pkg::REG_SYSTEM_OPEN:  system_open     <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read back a register
  always_comb begin
    case (reg_idx)
      ppt_pkg::REG_COEF_M00_M01: prdata = coef_m00_m01;
      ppt_pkg::REG_COEF_M02_M10: prdata = coef_m02_m10;
      ppt_pkg::REG_COEF_M11_M12: prdata = coef_m11_m12;
      ppt_pkg::REG_COEF_M20_M21: prdata = coef_m20_m21;
      ppt_pkg::REG_COEF_M22:     prdata = 64'(unsigned'(coef_m22));
      ppt_pkg::REG_NEAR_ZERO:    prdata = 64'(near_zero_limit);
      ppt_pkg::REG_SYSTEM_OPEN:  prdata = 64'(system_open);
      default:                   prdata = '0;
    endcase
  end

  // Matrix entries
  logic signed [31:0] m00, m01, m02, m10, m11, m12, m20, m21;
  assign m00 = coef_m00_m01[63:32];
  assign m01 = coef_m00_m01[31:0];
  assign m02 = coef_m02_m10[63:32];
  assign m10 = coef_m02_m10[31:0];
  assign m11 = coef_m11_m12[63:32];
  assign m12 = coef_m11_m12[31:0];
  assign m20 = coef_m20_m21[63:32];
  assign m21 = coef_m20_m21[31:0];

  // Whole pipeline advances unless the output register is held
  logic en;
  assign en          = !result_valid || result_ready;
  assign point_ready = en;

  // Stage 1: products
  logic                 v1;
  logic signed [PW-1:0] p00x, p01y, p10x, p11y, p20x, p21y;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= point_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p00x <= $signed(m00) * $signed(point.point_x);
      p01y <= $signed(m01) * $signed(point.point_y);
      p10x <= $signed(m10) * $signed(point.point_x);
      p11y <= $signed(m11) * $signed(point.point_y);
      p20x <= $signed(m20) * $signed(point.point_x);
      p21y <= $signed(m21) * $signed(point.point_y);
    end
  end

  // Stage 2: exact sums with the scaled constant terms
  logic                 v2;
  logic signed [SW-1:0] sum_w, sum_x, sum_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_w <= SW'(p20x) + SW'(p21y) + (SW'(coef_m22) <<< FRAC_BITS);
      sum_x <= SW'(p00x) + SW'(p01y) + (SW'(m02) <<< FRAC_BITS);
      sum_y <= SW'(p10x) + SW'(p11y) + (SW'(m12) <<< FRAC_BITS);
    end
  end

  // Stage 3: magnitudes, signs and status
  logic [SW-1:0]   mag_w, mag_x, mag_y;
  logic            near_zero;
  ppt_pkg::status_t stat2;

  assign mag_w = sum_w[SW-1] ? SW'(-sum_w) : SW'(sum_w);
  assign mag_x = sum_x[SW-1] ? SW'(-sum_x) : SW'(sum_x);
  assign mag_y = sum_y[SW-1] ? SW'(-sum_y) : SW'(sum_y);
  assign near_zero = (mag_w == '0) ||
                     (CMPW'(mag_w) < (CMPW'(near_zero_limit) << FRAC_BITS));

  always_comb begin
    if (!system_open) begin
      stat2 = ppt_pkg::STAT_CLOSED;
    end else if (near_zero) begin
      stat2 = ppt_pkg::STAT_NEAR_ZERO;
    end else begin
      stat2 = ppt_pkg::STAT_OK;
    end
  end

  logic            v3;
  ppt_pkg::ctl_t   ctl3;
  logic [NW-1:0]   num_x3, num_y3;
  logic [SW-1:0]   den3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl3.status <= stat2;
      ctl3.neg_x  <= sum_x[SW-1] ^ sum_w[SW-1];
      ctl3.neg_y  <= sum_y[SW-1] ^ sum_w[SW-1];
      num_x3      <= NW'(mag_x) << FRAC_BITS;
      num_y3      <= NW'(mag_y) << FRAC_BITS;
      den3        <= mag_w;
    end
  end

  // Divider pipelines, one per coordinate
  logic [QB-1:0] quo_x, quo_y;
  logic          ovf_x, ovf_y;

  ppt_div #(.NUM_W(NW), .DEN_W(SW), .QUO_W(QB)) u_div_x (
    .clk (clk), .en (en), .num (num_x3), .den (den3), .quo (quo_x), .ovf (ovf_x)
  );

  ppt_div #(.NUM_W(NW), .DEN_W(SW), .QUO_W(QB)) u_div_y (
    .clk (clk), .en (en), .num (num_y3), .den (den3), .quo (quo_y), .ovf (ovf_y)
  );

  // Carry valid and control alongside the dividers
  logic          dv   [LAT];
  ppt_pkg::ctl_t dctl [LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LAT; i++) dv[i] <= 1'b0;
    end else if (en) begin
      dv[0] <= v3;
      for (int i = 1; i < LAT; i++) dv[i] <= dv[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dctl[0] <= ctl3;
      for (int i = 1; i < LAT; i++) dctl[i] <= dctl[i-1];
    end
  end

  // Apply sign, saturate, zero on error
  function automatic logic signed [CW-1:0] sat_coord(
    input logic [QB-1:0] q, input logic ovf, input logic neg, input logic ok
  );
    logic [QB-1:0] half;
    logic signed [CW-1:0] v;
    half = QB'(1) << (CW - 1);
    if (!ok) begin
      v = '0;
    end else if (!neg) begin
      v = (ovf || q > half - QB'(1)) ? CW'(half - QB'(1)) : CW'(q);
    end else begin
      v = (ovf || q > half) ? CW'(half) : CW'(-q);
    end
    return v;
  endfunction

  logic out_ok;
  assign out_ok = dctl[LAT-1].status == ppt_pkg::STAT_OK;

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= dv[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.result_x <= sat_coord(quo_x, ovf_x, dctl[LAT-1].neg_x, out_ok);
      result.result_y <= sat_coord(quo_y, ovf_y, dctl[LAT-1].neg_y, out_ok);
      result.status   <= dctl[LAT-1].status;
    end
  end

  // Checks
  `PPT_ASSERT_IMPL(a_err_zero, result_valid && result.status != ppt_pkg::STAT_OK, result.result_x == 0 && result.result_y == 0, "error result carries nonzero coordinates")
  `PPT_ASSERT_IMPL(a_closed, result_valid && result.status == ppt_pkg::STAT_CLOSED, !system_open, "closed status while system open")
  `PPT_ASSERT(a_empty_after_reset, !$past(rst) || !result_valid, "result valid right after reset")

endmodule

[rtl/ppt_div.sv]
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
module ppt_div #(
  parameter int NUM_W = 82,
  parameter int DEN_W = 66,
  parameter int QUO_W = 33
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [QUO_W-1:0] quo,
  output logic             ovf
);

  localparam int XW = ((NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W) + 1;

  logic [NUM_W-1:0] rem_s [QUO_W];
  logic [DEN_W-1:0] den_s [QUO_W];
  logic [QUO_W-1:0] quo_s [QUO_W+1];
  logic             ovf_s [QUO_W+1];

  // Load operands and flag a quotient that does not fit
  always_ff @(posedge clk) begin
    if (en) begin
      rem_s[0] <= num;
      den_s[0] <= den;
      quo_s[0] <= '0;
      ovf_s[0] <= XW'(num) >= (XW'(den) << QUO_W);
    end
  end

  // One trial subtraction per stage, most significant bit first
  for (genvar k = 1; k <= QUO_W; k++) begin : g_stage
    localparam int SH = QUO_W - k;
    logic [XW-1:0] dsh;
    logic          take;
    assign dsh  = XW'(den_s[k-1]) << SH;
    assign take = XW'(rem_s[k-1]) >= dsh;

    always_ff @(posedge clk) begin
      if (en) begin
        quo_s[k] <= quo_s[k-1] | (take ? (QUO_W'(1) << SH) : QUO_W'(0));
        ovf_s[k] <= ovf_s[k-1];
      end
    end

    if (k < QUO_W) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_s[k] <= take ? NUM_W'(XW'(rem_s[k-1]) - dsh) : rem_s[k-1];
          den_s[k] <= den_s[k-1];
        end
      end
    end
  end

  assign quo = quo_s[QUO_W];
  assign ovf = ovf_s[QUO_W];

endmodule
